@@ rtl/signed_distance_field_texel_assert.svh @@
// assertion macros used by the port-level checker
`ifndef SIGNED_DISTANCE_FIELD_TEXEL_ASSERT_SVH
`define SIGNED_DISTANCE_FIELD_TEXEL_ASSERT_SVH

// condition implies property in the same cycle
`define SDF_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("sdf texel check failed");

// condition implies property in the next cycle
`define SDF_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("sdf texel check failed");

// next-cycle check that also runs during reset
`define SDF_ASSERT_ALWAYS(label, clk, cond, prop) \
  label: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error("sdf texel check failed");

`endif

@@ rtl/sdf_pkg.sv @@
// shared types, constants and helpers for the distance field texel block
`timescale 1ns / 1ps
`default_nettype none

package sdf_pkg;

  localparam int DEF_MAX_SRC_SIDE = 256;
  localparam int MAX_RADIUS       = 16;
  localparam int FIFO_DEPTH       = 2;

  // code arithmetic constants
  localparam logic signed [21:0] CODE_MID  = 22'sd32512;
  localparam logic [19:0]        CODE_GAIN = 20'd127;
  localparam logic [7:0]         CODE_MAX  = 8'd255;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH       = 3'd0,
    REG_SRC_HEIGHT      = 3'd1,
    REG_DST_WIDTH       = 3'd2,
    REG_DST_HEIGHT      = 3'd3,
    REG_SEARCH_RADIUS   = 3'd4,
    REG_ALPHA_THRESHOLD = 3'd5,
    REG_WRAP_HORIZONTAL = 3'd6,
    REG_WRAP_VERTICAL   = 3'd7
  } reg_idx_t;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef struct packed {
    logic [8:0] src_width;
    logic [8:0] src_height;
    logic [8:0] dst_width;
    logic [8:0] dst_height;
    logic [4:0] search_radius;
    logic [7:0] alpha_threshold;
    logic       wrap_horizontal;
    logic       wrap_vertical;
  } cfg_t;

  // queue entry: a pixel write or a mapped query
  typedef struct packed {
    logic       query;
    logic [8:0] x;
    logic [8:0] y;
    logic [7:0] alpha;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MA, F_MB, F_MD, F_MN, F_DIV, F_CLAMP, F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_START, B_CENTER, B_WRAPX, B_WRAPY, B_SCAN, B_DRAIN,
    B_SQINIT, B_SQRT, B_MUL, B_DIV, B_FIN
  } back_state_t;

  // zero counts as one, anything above top counts as top
  function automatic logic [8:0] clamp_side(logic [8:0] v, logic [8:0] top);
    logic [8:0] res;
    if (v == 9'd0) res = 9'd1;
    else if (v > top) res = top;
    else res = v;
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/signed_distance_field_texel.sv @@
// top level of the signed distance field texel generator
//
//  channel  signals                                   dir  transfer when
//  in       in_valid/in_ready, func, coord_x/y, alpha  in   in_valid & in_ready
//  out      out_valid/out_ready, distance_code         out  out_valid & out_ready
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data   in   cfg_valid & cfg_ready
//
// a pixel write goes from the front part through the queue to the memory in the back part.
// a query is mapped to a source pixel in the front (one division per axis) and
// searched in the back, one window pixel per memory read.
// front and back overlap through a two-entry queue; the result register lets the
// back part go on with queued writes while a result waits.
// reset clears control state only; the image is undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module signed_distance_field_texel import sdf_pkg::*; #(
  parameter int MAX_SRC_SIDE = DEF_MAX_SRC_SIDE
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [7:0] coord_x,
  input  logic [7:0] coord_y,
  input  logic [7:0] pixel_alpha,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] distance_code,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data
);

  cfg_t         cfg;
  logic         push, pop;
  item_t        push_item, pop_item;
  fifo_status_t fstat;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width       <= 9'd256;
      cfg.src_height      <= 9'd256;
      cfg.dst_width       <= 9'd64;
      cfg.dst_height      <= 9'd64;
      cfg.search_radius   <= 5'd8;
      cfg.alpha_threshold <= 8'd0;
      cfg.wrap_horizontal <= 1'b0;
      cfg.wrap_vertical   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_SRC_WIDTH:       cfg.src_width       <= cfg_data;
        REG_SRC_HEIGHT:      cfg.src_height      <= cfg_data;
        REG_DST_WIDTH:       cfg.dst_width       <= cfg_data;
        REG_DST_HEIGHT:      cfg.dst_height      <= cfg_data;
        REG_SEARCH_RADIUS:   cfg.search_radius   <= cfg_data[4:0];
        REG_ALPHA_THRESHOLD: cfg.alpha_threshold <= cfg_data[7:0];
        REG_WRAP_HORIZONTAL: cfg.wrap_horizontal <= cfg_data[0];
        REG_WRAP_VERTICAL:   cfg.wrap_vertical   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sdf_front #(.MAX_SRC_SIDE(MAX_SRC_SIDE)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .pixel_alpha (pixel_alpha),
    .push        (push),
    .push_item   (push_item),
    .fstat       (fstat)
  );

  sdf_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (fstat)
  );

  sdf_back #(.MAX_SRC_SIDE(MAX_SRC_SIDE)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .pop_item      (pop_item),
    .fstat         (fstat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .distance_code (distance_code)
  );

endmodule

`default_nettype wire

@@ rtl/sdf_fifo.sv @@
// two-entry queue between the front and back parts
`timescale 1ns / 1ps
`default_nettype none

module sdf_fifo import sdf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  item_t        push_item,
  input  logic         pop,
  output item_t        pop_item,
  output fifo_status_t status
);

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  item_t           slots [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign status.full  = (count == CntW'(FIFO_DEPTH));
  assign status.empty = (count == '0);
  assign pop_item     = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sdf_front.sv @@
// front part: takes items, drops out-of-range writes, maps query texels to source pixels
`timescale 1ns / 1ps
`default_nettype none

module sdf_front import sdf_pkg::*; #(
  parameter int MAX_SRC_SIDE = DEF_MAX_SRC_SIDE
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         func,
  input  logic [7:0]   coord_x,
  input  logic [7:0]   coord_y,
  input  logic [7:0]   pixel_alpha,
  output logic         push,
  output item_t        push_item,
  input  fifo_status_t fstat
);

  localparam int SideTop = (MAX_SRC_SIDE > 511) ? 511 : MAX_SRC_SIDE;

  front_state_t state, state_next;

  logic              axis;
  logic [7:0]        cx, cy;
  logic [17:0]       prod_a;
  logic signed [19:0] prod_b;
  logic [18:0]       den;
  logic [27:0]       rem;
  logic [27:0]       dsh;
  logic [8:0]        quo;
  logic [3:0]        step;
  logic [8:0]        xo, yo;

  logic [8:0]        s, w, d1, wm1, qpos;
  logic [7:0]        c;
  logic signed [9:0] sdiff;
  logic signed [28:0] numv;
  logic [25:0]       ac;
  logic              ge, wr_ok, accept;

  // per-axis operands
  always_comb begin
    s     = axis ? clamp_side(cfg.src_height, 9'(SideTop))
                 : clamp_side(cfg.src_width, 9'(SideTop));
    w     = axis ? clamp_side(cfg.dst_height, 9'd511)
                 : clamp_side(cfg.dst_width, 9'd511);
    c     = axis ? cy : cx;
    wm1   = w - 9'd1;
    d1    = (w > 9'd1) ? wm1 : 9'd1;
    sdiff = $signed({1'b0, s}) - $signed({1'b0, w});
    ac    = 26'(prod_a) * 26'(c);
    numv  = $signed({2'b00, ac, 1'b0}) + 29'(prod_b);
    ge    = (rem >= dsh);
    qpos  = (quo > s - 9'd1) ? s - 9'd1 : quo;
    wr_ok = (int'(coord_x) < MAX_SRC_SIDE) && (int'(coord_y) < MAX_SRC_SIDE);
  end

  assign accept = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and queue outputs
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    push       = 1'b0;
    push_item  = '{query: 1'b0, x: 9'(coord_x), y: 9'(coord_y), alpha: pixel_alpha};
    case (state)
      F_IDLE: begin
        in_ready = !fstat.full;
        if (accept) begin
          if (func == FUNC_WRITE) push = wr_ok;
          else state_next = F_MA;
        end
      end
      F_MA: state_next = F_MB;
      F_MB: state_next = F_MD;
      F_MD: state_next = F_MN;
      F_MN: state_next = numv[28] ? F_CLAMP : F_DIV;
      F_DIV: begin
        if ((step == 4'd9 && ge) || step == 4'd0) state_next = F_CLAMP;
      end
      F_CLAMP: state_next = axis ? F_PUSH : F_MA;
      F_PUSH: begin
        push_item = '{query: 1'b1, x: xo, y: yo, alpha: 8'd0};
        if (!fstat.full) begin
          push       = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // mapping datapath
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (accept) begin
          cx   <= coord_x;
          cy   <= coord_y;
          axis <= 1'b0;
        end
      end
      F_MA: prod_a <= 18'(s) * 18'(wm1);
      F_MB: prod_b <= 20'(sdiff) * $signed({11'b0, d1});
      F_MD: den <= {18'(18'(w) * 18'(d1)), 1'b0};
      F_MN: begin
        rem  <= numv[27:0];
        dsh  <= {den, 9'b0};
        step <= 4'd9;
        quo  <= '0;
      end
      F_DIV: begin
        if (step == 4'd9) begin
          if (ge) quo <= 9'h1FF;
        end else begin
          if (ge) rem <= rem - dsh;
          quo <= {quo[7:0], ge};
        end
        dsh  <= dsh >> 1;
        step <= step - 4'd1;
      end
      F_CLAMP: begin
        if (axis) yo <= qpos;
        else xo <= qpos;
        axis <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/sdf_back.sv @@
// back part: source image memory, window scan, root and scaling of the distance
`timescale 1ns / 1ps
`default_nettype none

module sdf_back import sdf_pkg::*; #(
  parameter int MAX_SRC_SIDE = DEF_MAX_SRC_SIDE
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  item_t        pop_item,
  input  fifo_status_t fstat,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   distance_code
);

  localparam int Depth   = MAX_SRC_SIDE * MAX_SRC_SIDE;
  localparam int AW      = $clog2(Depth);
  localparam int SideTop = (MAX_SRC_SIDE > 511) ? 511 : MAX_SRC_SIDE;

  function automatic logic [AW-1:0] pix_addr(logic [8:0] x, logic [8:0] y);
    return AW'(AW'(y) * AW'(MAX_SRC_SIDE)) + AW'(x);
  endfunction

  back_state_t state, state_next;

  logic [7:0]  mem [Depth];
  logic [7:0]  rdata;
  logic [AW-1:0] raddr, waddr;
  logic        we;

  logic [8:0]  xo, yo;
  logic [4:0]  rr;
  logic        transp;
  logic [9:0]  best;
  logic signed [6:0]  dx, dy;
  logic signed [10:0] px, py, px0;
  logic        s_v;
  logic [10:0] s_d;
  logic [25:0] v, res, bitm;
  logic [19:0] n;
  logic [4:0]  rem;
  logic [4:0]  cnt;

  logic [8:0]  sw, sh;
  logic [4:0]  r;
  logic signed [10:0] rs, sws, shs, px_inc, py_inc;
  logic signed [13:0] dx2, dy2;
  logic [10:0] d_a;
  logic        x_ok, y_ok, row_end, col_end, sq_ge, dv_ge, fin_load;
  logic [25:0] trial;
  logic [5:0]  t;
  logic signed [21:0] vv;
  logic [7:0]  code;

  // effective settings and scan helpers
  always_comb begin
    sw      = clamp_side(cfg.src_width, 9'(SideTop));
    sh      = clamp_side(cfg.src_height, 9'(SideTop));
    r       = 5'(clamp_side(9'(cfg.search_radius), 9'(MAX_RADIUS)));
    rs      = $signed({6'b0, rr});
    sws     = $signed({2'b0, sw});
    shs     = $signed({2'b0, sh});
    x_ok    = cfg.wrap_horizontal || (px >= 0 && px < sws);
    y_ok    = cfg.wrap_vertical || (py >= 0 && py < shs);
    px_inc  = (cfg.wrap_horizontal && px + 11'sd1 == sws) ? 11'sd0 : px + 11'sd1;
    py_inc  = (cfg.wrap_vertical && py + 11'sd1 == shs) ? 11'sd0 : py + 11'sd1;
    dx2     = dx * dx;
    dy2     = dy * dy;
    d_a     = 11'(dx2) + 11'(dy2);
    col_end = (dx == 7'(rs));
    row_end = (dy == 7'(rs));
    trial   = res + bitm;
    sq_ge   = (v >= trial);
    t       = {rem, n[19]};
    dv_ge   = (t >= {1'b0, rr});
    vv      = transp ? CODE_MID - $signed({2'b0, n}) : CODE_MID + $signed({2'b0, n});
    if (vv < 0) code = 8'd0;
    else if (vv[21:8] > 14'(CODE_MAX)) code = CODE_MAX;
    else code = vv[15:8];
  end

  // memory ports
  assign pop   = (state == B_IDLE) && !fstat.empty;
  assign we    = pop && !pop_item.query;
  assign waddr = pix_addr(pop_item.x, pop_item.y);
  assign raddr = (state == B_START) ? pix_addr(xo, yo) : pix_addr(px[8:0], py[8:0]);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= pop_item.alpha;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    fin_load   = 1'b0;
    case (state)
      B_IDLE:   if (pop && pop_item.query) state_next = B_START;
      B_START:  state_next = B_CENTER;
      B_CENTER: state_next = B_WRAPX;
      B_WRAPX:  if (!(cfg.wrap_horizontal && px0 < 0)) state_next = B_WRAPY;
      B_WRAPY:  if (!(cfg.wrap_vertical && py < 0)) state_next = B_SCAN;
      B_SCAN:   if (col_end && row_end) state_next = B_DRAIN;
      B_DRAIN:  state_next = B_SQINIT;
      B_SQINIT: state_next = B_SQRT;
      B_SQRT:   if (bitm[0]) state_next = B_MUL;
      B_MUL:    state_next = B_DIV;
      B_DIV:    if (cnt == 5'd0) state_next = B_FIN;
      B_FIN: begin
        if (!out_valid || out_ready) begin
          fin_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // scan pipeline stage: valid position and its distance
  always_ff @(posedge clk) begin
    if (rst) begin
      s_v <= 1'b0;
    end else begin
      s_v <= (state == B_SCAN) && x_ok && y_ok;
    end
    s_d <= d_a;
  end

  // query datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        xo <= pop_item.x;
        yo <= pop_item.y;
      end
      B_START: begin
        rr   <= r;
        best <= 10'(10'(r) * 10'(r));
        px0  <= $signed({2'b0, xo}) - $signed({6'b0, r});
        py   <= $signed({2'b0, yo}) - $signed({6'b0, r});
        dx   <= -$signed({2'b0, r});
        dy   <= -$signed({2'b0, r});
      end
      B_CENTER: transp <= (rdata <= cfg.alpha_threshold);
      B_WRAPX: begin
        if (cfg.wrap_horizontal && px0 < 0) px0 <= px0 + sws;
        else px <= px0;
      end
      B_WRAPY: begin
        if (cfg.wrap_vertical && py < 0) py <= py + shs;
      end
      B_SCAN: begin
        if (col_end) begin
          dx <= -7'(rs);
          px <= px0;
          dy <= dy + 7'sd1;
          py <= py_inc;
        end else begin
          dx <= dx + 7'sd1;
          px <= px_inc;
        end
      end
      B_SQINIT: begin
        v    <= {best, 16'b0};
        res  <= '0;
        bitm <= 26'(1) << 24;
      end
      B_SQRT: begin
        if (sq_ge) begin
          v   <= v - trial;
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
      end
      B_MUL: begin
        n   <= 20'(res[12:0]) * CODE_GAIN;
        rem <= '0;
        cnt <= 5'd19;
      end
      B_DIV: begin
        rem <= dv_ge ? 5'(t - {1'b0, rr}) : t[4:0];
        n   <= {n[18:0], dv_ge};
        cnt <= cnt - 5'd1;
      end
      default: ;
    endcase
    // nearest pixel of the other class so far
    if (s_v && ((rdata <= cfg.alpha_threshold) != transp) && s_d < {1'b0, best}) begin
      best <= s_d[9:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (fin_load) distance_code <= code;
  end

endmodule

`default_nettype wire

@@ rtl/sdf_checker.sv @@
// port-level checks for the texel block and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "signed_distance_field_texel_assert.svh"

module sdf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       func,
  input logic [7:0] coord_x,
  input logic [7:0] coord_y,
  input logic [7:0] pixel_alpha,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] distance_code,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [2:0] cfg_index,
  input logic [8:0] cfg_data
);

  // a stalled result stays offered
  `SDF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // a stalled result keeps its code
  `SDF_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(distance_code))
  // no result is offered right after reset
  `SDF_ASSERT_ALWAYS(a_reset_quiet, clk, rst, !out_valid)
  // register writes never stall
  `SDF_ASSERT_NOW(a_cfg_ready, clk, rst, cfg_valid, cfg_ready)

endmodule

bind signed_distance_field_texel sdf_checker u_sdf_checker (.*);

`default_nettype wire

@@ sim/signed_distance_field_texel_checker.sv @@
// checker for the distance field texel block: predicts codes and compares transfers
`timescale 1ns / 1ps

module signed_distance_field_texel_checker import sdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       func,
  input  logic [7:0] coord_x,
  input  logic [7:0] coord_y,
  input  logic [7:0] pixel_alpha,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] distance_code,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  logic [7:0] alpha_mem [0:65535];
  cfg_t       regs;
  logic [7:0] code_q [$];
  int         reported;

  initial begin
    fail_count = 0;
    pending    = 0;
    reported   = 0;
  end

  // zero counts as one, above top counts as top
  function automatic longint eff_side(longint v, longint top);
    if (v < 1) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // destination texel to source pixel, exact rational form
  function automatic longint map_texel(longint c, longint s, longint w);
    longint d1, num, den, q;
    d1 = ((w > 1) ? w : 2) - 1;
    num = 2 * s * (w - 1) * c + (s - w) * d1;
    den = 2 * w * d1;
    q = num / den;
    if (q < 0) q = 0;
    if (q > s - 1) q = s - 1;
    return q;
  endfunction

  // bitwise integer square root
  function automatic logic [31:0] int_root(logic [31:0] v);
    logic [31:0] res, bitv;
    res = 0;
    bitv = 32'h4000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic bit is_clear(longint x, longint y);
    return alpha_mem[x + y * 256] <= regs.alpha_threshold;
  endfunction

  // full window search and code for one query
  function automatic logic [7:0] texel_code(longint cx, longint cy);
    longint sw, sh, dw, dh, r, xo, yo, best, px, py, d, m, v;
    bit     clear_px, ok_y;
    logic [31:0] q;
    sw = eff_side(regs.src_width, 256);
    sh = eff_side(regs.src_height, 256);
    dw = eff_side(regs.dst_width, 511);
    dh = eff_side(regs.dst_height, 511);
    r  = eff_side(regs.search_radius, MAX_RADIUS);
    xo = map_texel(cx, sw, dw);
    yo = map_texel(cy, sh, dh);
    clear_px = is_clear(xo, yo);
    best = r * r;
    for (longint dy = -r; dy <= r; dy++) begin
      py = yo + dy;
      ok_y = 1;
      if (regs.wrap_vertical) begin
        py = py % sh;
        if (py < 0) py += sh;
      end else if (py < 0 || py >= sh) begin
        ok_y = 0;
      end
      if (ok_y) begin
        for (longint dx = -r; dx <= r; dx++) begin
          px = xo + dx;
          if (regs.wrap_horizontal) begin
            px = px % sw;
            if (px < 0) px += sw;
          end
          if (regs.wrap_horizontal || (px >= 0 && px < sw)) begin
            d = dx * dx + dy * dy;
            if (is_clear(px, py) != clear_px && d < best) best = d;
          end
        end
      end
    end
    q = int_root(32'(best) << 16);
    m = (127 * longint'(q)) / r;
    v = clear_px ? (32512 - m) : (32512 + m);
    if (v < 0) v = 0;
    v = v >>> 8;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // follow config, inputs and results at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      regs.src_width       = 9'd256;
      regs.src_height      = 9'd256;
      regs.dst_width       = 9'd64;
      regs.dst_height      = 9'd64;
      regs.search_radius   = 5'd8;
      regs.alpha_threshold = 8'd0;
      regs.wrap_horizontal = 1'b0;
      regs.wrap_vertical   = 1'b0;
      code_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_SRC_WIDTH:       regs.src_width       = cfg_data;
          REG_SRC_HEIGHT:      regs.src_height      = cfg_data;
          REG_DST_WIDTH:       regs.dst_width       = cfg_data;
          REG_DST_HEIGHT:      regs.dst_height      = cfg_data;
          REG_SEARCH_RADIUS:   regs.search_radius   = cfg_data[4:0];
          REG_ALPHA_THRESHOLD: regs.alpha_threshold = cfg_data[7:0];
          REG_WRAP_HORIZONTAL: regs.wrap_horizontal = cfg_data[0];
          REG_WRAP_VERTICAL:   regs.wrap_vertical   = cfg_data[0];
          default: ;
        endcase
      end
      // result transfer against the oldest expected code
      if (out_valid && out_ready) begin
        if (code_q.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            reported++;
            $display("unexpected distance code %0d", distance_code);
          end
        end else begin
          if (code_q[0] !== distance_code) begin
            fail_count++;
            if (reported < 10) begin
              reported++;
              $display("distance_code mismatch: expected %0d got %0d",
                       code_q[0], distance_code);
            end
          end
          void'(code_q.pop_front());
        end
      end
      // input transfer: store pixel or predict code
      if (in_valid && in_ready) begin
        if (func_t'(func) == FUNC_QUERY)
          code_q.push_back(texel_code(coord_x, coord_y));
        else
          alpha_mem[{coord_y, coord_x}] = pixel_alpha;
      end
    end
    pending = code_q.size();
  end

endmodule

@@ sim/signed_distance_field_texel_test.sv @@
// stimulus and verdict for the distance field texel block
`timescale 1ns / 1ps

module signed_distance_field_texel_test import sdf_pkg::*;;

  localparam longint CYCLE_LIMIT = 6_000_000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       func = 1'b0;
  logic [7:0] coord_x = '0;
  logic [7:0] coord_y = '0;
  logic [7:0] pixel_alpha = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] distance_code;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;
  int         fail_count;
  int         pending;
  longint     cycle_count = 0;
  int         items_sent = 0;
  int         eff_w, eff_h;

  signed_distance_field_texel dut (.*);

  signed_distance_field_texel_checker checker_i (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // no idling on either side inside this window
  function automatic bit may_idle();
    return !(cycle_count > 30000 && cycle_count < 90000);
  endfunction

  // result side stalls
  always @(negedge clk)
    out_ready = !(may_idle() && $urandom_range(99) < 12);

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("signed_distance_field_texel_test NOT OK");
      $finish;
    end
  end

  task automatic send_item(func_t f, int x, int y, int a);
    @(negedge clk);
    while (may_idle() && $urandom_range(99) < 12) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    func = f;
    coord_x = 8'(x);
    coord_y = 8'(y);
    pixel_alpha = 8'(a);
    items_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(reg_idx_t idx, int d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = 9'(d);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait out every expected code plus a trailing pixel write
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic int side_of(int v);
    if (v < 1) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  // program all registers, then fill the source area with a noisy disc
  task automatic setup(int sw, int sh, int dw, int dh, int r, int thr, int wh, int wv);
    int cx, cy, rad, a;
    drain();
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    write_reg(REG_SEARCH_RADIUS, r);
    write_reg(REG_ALPHA_THRESHOLD, thr);
    write_reg(REG_WRAP_HORIZONTAL, wh);
    write_reg(REG_WRAP_VERTICAL, wv);
    eff_w = side_of(sw);
    eff_h = side_of(sh);
    cx = $urandom_range(eff_w - 1);
    cy = $urandom_range(eff_h - 1);
    rad = $urandom_range(1, (eff_w > eff_h ? eff_w : eff_h) / 2 + 1);
    for (int y = 0; y < eff_h; y++)
      for (int x = 0; x < eff_w; x++) begin
        if ($urandom_range(99) < 5) a = $urandom_range(255);
        else if ((x - cx) * (x - cx) + (y - cy) * (y - cy) < rad * rad)
          a = $urandom_range(128, 255);
        else a = $urandom_range(0, 127);
        send_item(FUNC_WRITE, x, y, a);
      end
  endtask

  // mostly queries, some pixel rewrites inside the source area
  task automatic mixed_traffic(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 20)
        send_item(FUNC_WRITE, $urandom_range(eff_w - 1), $urandom_range(eff_h - 1),
                  $urandom_range(255));
      else
        send_item(FUNC_QUERY, $urandom_range(255), $urandom_range(255),
                  $urandom_range(255));
    end
  endtask

  task automatic corner_queries();
    send_item(FUNC_QUERY, 0, 0, 0);
    send_item(FUNC_QUERY, 255, 255, 255);
    send_item(FUNC_QUERY, 0, 255, 170);
    send_item(FUNC_QUERY, 255, 0, 85);
  endtask

  initial begin
    int sw, sh, lim, r;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed settings, extremes of every register
    setup(8, 8, 4, 4, 3, 100, 0, 0);
    corner_queries();
    for (int i = 0; i < 8; i++) send_item(FUNC_QUERY, i, 7 - i, 255);
    setup(8, 8, 8, 8, 3, 0, 1, 1);
    corner_queries();
    mixed_traffic(20);
    setup(8, 8, 4, 4, 2, 255, 0, 1);
    corner_queries();
    // zero and oversized sides, zero radius, one-texel-wide destination
    setup(0, 511, 1, 256, 0, 128, 1, 0);
    corner_queries();
    mixed_traffic(20);
    // radius not below the sides, wrap then clamp, oversized radius
    setup(5, 3, 300, 511, 31, 128, 1, 1);
    mixed_traffic(30);
    setup(5, 3, 7, 2, 8, 128, 0, 0);
    mixed_traffic(30);
    // largest window over a source just wider than its radius
    setup(17, 17, 256, 256, 16, 128, $urandom_range(1), $urandom_range(1));
    corner_queries();
    mixed_traffic(16);

    // random settings, small sources and radii
    while (items_sent < 1800) begin
      sw = $urandom_range(2, 12);
      sh = $urandom_range(2, 12);
      lim = (sw < sh ? sw : sh) - 1;
      if (lim > 16) lim = 16;
      r = $urandom_range(1, lim < 6 ? lim : 6);
      if ($urandom_range(9) == 0) r = $urandom_range(1, lim);
      setup(sw, sh, $urandom_range(1, 300), $urandom_range(1, 300), r,
            $urandom_range(90, 160), $urandom_range(1), $urandom_range(1));
      mixed_traffic(40);
    end

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("signed_distance_field_texel_test OK");
    else
      $display("signed_distance_field_texel_test NOT OK");
    $finish;
  end

endmodule

@@ signed_distance_field_texel.f @@
+incdir+rtl
rtl/sdf_pkg.sv
rtl/sdf_fifo.sv
rtl/sdf_front.sv
rtl/sdf_back.sv
rtl/signed_distance_field_texel.sv
rtl/sdf_checker.sv
sim/signed_distance_field_texel_checker.sv
sim/signed_distance_field_texel_test.sv
